// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/prrts_pkg.sv =====
// ----------------------------------------------------------------------------
// prrts_pkg
// Types, codes and constants of the priority round-robin task scheduler.
// ----------------------------------------------------------------------------
package prrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] IDLE_SLOT = '0;
  localparam logic [7:0] IDLE_PRIORITY = 8'd255;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_ACTIVATE  = 3'd1,
    OP_TERMINATE = 3'd2,
    OP_WAIT      = 3'd3,
    OP_TICK      = 3'd4,
    OP_START     = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_ACTIVE     = 3'd1,
    STS_TERMINATED = 3'd2,
    STS_FULL       = 3'd3,
    STS_BAD_ID     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TS_SUSP  = 2'd0,
    TS_WAIT  = 2'd1,
    TS_READY = 2'd2,
    TS_RUN   = 2'd3
  } task_st_t;

  typedef struct packed {
    logic [7:0]  prio;
    task_st_t    st;
    logic        blk;
    logic [15:0] delay;
  } task_ent_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    task_ent_t        data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] id;
  } fifo_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CHK, S_RB_INIT, S_RB1_RD, S_RB1_PR, S_RB2_RD, S_RB2_PR,
    S_TK_RD, S_TK_PR, S_NX_RD, S_NX_CUR, S_NX_NXT, S_NX_CURW, S_DONE
  } fsm_t;

  // Entry value of a slot that was never written since reset.
  function automatic task_ent_t ent_reset(input logic [IDX_W-1:0] idx);
    task_ent_t e;
    e.prio  = (idx == IDLE_SLOT) ? IDLE_PRIORITY : 8'd0;
    e.st    = TS_SUSP;
    e.blk   = 1'b0;
    e.delay = 16'd0;
    return e;
  endfunction

endpackage

// ===== sv/prrts_if.sv =====
// ----------------------------------------------------------------------------
// prrts_req_if / prrts_rsp_if
// Valid/ready channels carrying scheduler commands and results.
// ----------------------------------------------------------------------------
interface prrts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  task_id;
  logic [7:0]  priority_req;
  logic [15:0] wait_ticks;

  modport source (output valid, opcode, task_id, priority_req, wait_ticks, input ready);
  modport sink   (input valid, opcode, task_id, priority_req, wait_ticks, output ready);
endinterface

interface prrts_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] new_task_id;
  logic [2:0] running_task;
  logic       switch_request;
  logic [3:0] ready_count;

  modport source (output valid, status, new_task_id, running_task, switch_request,
                  ready_count, input ready);
  modport sink   (input valid, status, new_task_id, running_task, switch_request,
                  ready_count, output ready);
endinterface

// ===== sv/prrts_table.sv =====
// ----------------------------------------------------------------------------
// prrts_table
// Task table memory, one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module prrts_table (
  input  logic                          clk,
  input  logic                          rst,
  input  prrts_pkg::tbl_wr_t            wr,
  input  logic [prrts_pkg::IDX_W-1:0]   raddr,
  output prrts_pkg::task_ent_t          rdata
);

  prrts_pkg::task_ent_t               mem [prrts_pkg::MAX_TASKS];
  logic [prrts_pkg::MAX_TASKS-1:0]    written;
  prrts_pkg::task_ent_t               rd_q;
  logic                               rd_valid;
  logic [prrts_pkg::IDX_W-1:0]        rd_addr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q    <= mem[raddr];
    rd_addr <= raddr;
  end

  // Valid bits stand in for clearing the table at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      rd_valid <= written[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : prrts_pkg::ent_reset(rd_addr);

endmodule

// ===== sv/prrts_fifo.sv =====
// ----------------------------------------------------------------------------
// prrts_fifo
// Ready queue storage; head and fill are kept by the controller.
// ----------------------------------------------------------------------------
module prrts_fifo (
  input  logic                          clk,
  input  prrts_pkg::fifo_wr_t           wr,
  input  logic [prrts_pkg::IDX_W-1:0]   raddr,
  output logic [prrts_pkg::IDX_W-1:0]   rdata
);

  logic [prrts_pkg::IDX_W-1:0] mem [prrts_pkg::MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.id;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/priority_round_robin_task_scheduler_top.sv =====
// Cost: create, errors and unused codes need no table scan; a rebuild walks the
//   table twice, a tick scan walks it once, and the next-task step reads the queue head.
// Commands: one at a time, a new one is taken only back in idle; the pace is
//   set by the table memory's single read port that every table scan walks slot by slot.
// Reset (synchronous, active high): idle task only, scheduler stopped, queue empty.
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top
// Fixed-priority round-robin task scheduler built around a task table memory
// and a ready queue memory, driven by a scan sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_round_robin_task_scheduler_top (
  input  logic         clk,
  input  logic         rst,
  prrts_req_if.sink    req,
  prrts_rsp_if.source  rsp
);

  localparam int NT = prrts_pkg::MAX_TASKS;
  localparam int IW = prrts_pkg::IDX_W;
  localparam int CW = prrts_pkg::CNT_W;

  // Sequencer state and scheduler registers.
  prrts_pkg::fsm_t   state, state_next;
  logic [2:0]        op_q, op_q_next;
  logic [IW-1:0]     id_q, id_q_next;
  logic [7:0]        prio_q, prio_q_next;
  logic [15:0]       ticks_q, ticks_q_next;
  logic [2:0]        status, status_next;
  logic [IW-1:0]     new_id, new_id_next;
  logic              sw, sw_next;
  logic              do_next, do_next_next;
  logic              woke, woke_next;
  logic [CW-1:0]     task_count, task_count_next;
  logic [IW-1:0]     head, head_next;
  logic [CW-1:0]     fill, fill_next;
  logic [IW-1:0]     cur, cur_next;
  logic              running, running_next;
  logic [CW-1:0]     idx, idx_next;
  logic [8:0]        best, best_next;
  prrts_pkg::task_ent_t cur_ent, cur_ent_next;
  logic [IW-1:0]     nxt_id, nxt_id_next;

  // Result register, parts the output side from the sequencer.
  logic              out_valid, out_valid_next;
  logic [2:0]        out_status;
  logic [IW-1:0]     out_new_id;
  logic [IW-1:0]     out_running;
  logic              out_sw;
  logic [CW-1:0]     out_count;
  logic              out_load;

  // Memory ports.
  prrts_pkg::tbl_wr_t   tbl_wr;
  logic [IW-1:0]        tbl_raddr;
  prrts_pkg::task_ent_t ent;
  prrts_pkg::fifo_wr_t  fifo_wr;
  logic [IW-1:0]        fifo_raddr;
  logic [IW-1:0]        fifo_rdata;
  logic [IW-1:0]        push_addr;

  prrts_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (tbl_wr),
    .raddr (tbl_raddr),
    .rdata (ent)
  );

  prrts_fifo u_fifo (
    .clk   (clk),
    .wr    (fifo_wr),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  // Tail slot of the ready queue: head plus fill, wrapping.
  assign push_addr = head + fill[IW-1:0];

  assign req.ready = (state == prrts_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    id_q_next       = id_q;
    prio_q_next     = prio_q;
    ticks_q_next    = ticks_q;
    status_next     = status;
    new_id_next     = new_id;
    sw_next         = sw;
    do_next_next    = do_next;
    woke_next       = woke;
    task_count_next = task_count;
    head_next       = head;
    fill_next       = fill;
    cur_next        = cur;
    running_next    = running;
    idx_next        = idx;
    best_next       = best;
    cur_ent_next    = cur_ent;
    nxt_id_next     = nxt_id;
    tbl_wr          = '0;
    tbl_raddr       = idx[IW-1:0];
    fifo_wr         = '0;
    fifo_raddr      = head;
    out_load        = 1'b0;

    unique case (state)
      prrts_pkg::S_IDLE: begin
        if (req.valid) begin
          op_q_next    = req.opcode;
          id_q_next    = req.task_id;
          prio_q_next  = req.priority_req;
          ticks_q_next = req.wait_ticks;
          status_next  = prrts_pkg::STS_OK;
          new_id_next  = '0;
          sw_next      = 1'b0;
          state_next   = prrts_pkg::S_DECODE;
        end
      end

      prrts_pkg::S_DECODE: begin
        unique case (op_q)
          prrts_pkg::OP_CREATE: begin
            if (task_count >= CW'(NT)) begin
              status_next = prrts_pkg::STS_FULL;
            end else begin
              tbl_wr.en         = 1'b1;
              tbl_wr.addr       = task_count[IW-1:0];
              tbl_wr.data.prio  = prio_q;
              tbl_wr.data.st    = prrts_pkg::TS_SUSP;
              tbl_wr.data.blk   = 1'b0;
              tbl_wr.data.delay = '0;
              new_id_next       = task_count[IW-1:0];
              task_count_next   = task_count + CW'(1);
            end
            state_next = prrts_pkg::S_DONE;
          end
          prrts_pkg::OP_ACTIVATE, prrts_pkg::OP_TERMINATE, prrts_pkg::OP_WAIT: begin
            if (CW'(id_q) >= task_count) begin
              status_next = prrts_pkg::STS_BAD_ID;
              state_next  = prrts_pkg::S_DONE;
            end else begin
              tbl_raddr  = id_q;
              state_next = prrts_pkg::S_CHK;
            end
          end
          prrts_pkg::OP_TICK: begin
            if (!running) begin
              state_next = prrts_pkg::S_DONE;
            end else begin
              idx_next     = '0;
              woke_next    = 1'b0;
              do_next_next = 1'b1;
              sw_next      = 1'b1;
              state_next   = prrts_pkg::S_TK_RD;
            end
          end
          prrts_pkg::OP_START: begin
            running_next = 1'b1;
            cur_next     = prrts_pkg::IDLE_SLOT;
            id_q_next    = prrts_pkg::IDLE_SLOT;
            tbl_raddr    = prrts_pkg::IDLE_SLOT;
            state_next   = prrts_pkg::S_CHK;
          end
          default: begin
            state_next = prrts_pkg::S_DONE;
          end
        endcase
      end

      // Check and update the addressed slot, then rebuild the queue unless the status is an error.
      prrts_pkg::S_CHK: begin
        do_next_next = running && (cur != prrts_pkg::IDLE_SLOT);
        sw_next      = running && (cur != prrts_pkg::IDLE_SLOT);
        tbl_wr.addr  = id_q;
        tbl_wr.data  = ent;
        state_next   = prrts_pkg::S_RB_INIT;
        priority case (op_q)
          prrts_pkg::OP_TERMINATE: begin
            if (ent.st == prrts_pkg::TS_SUSP) begin
              status_next = prrts_pkg::STS_TERMINATED;
              sw_next     = 1'b0;
              state_next  = prrts_pkg::S_DONE;
            end else begin
              tbl_wr.en      = 1'b1;
              tbl_wr.data.st = prrts_pkg::TS_SUSP;
            end
          end
          prrts_pkg::OP_WAIT: begin
            tbl_wr.en         = 1'b1;
            tbl_wr.data.st    = prrts_pkg::TS_SUSP;
            tbl_wr.data.blk   = 1'b1;
            tbl_wr.data.delay = ticks_q;
          end
          default: begin
            // Activate, and start on the idle task.
            if (ent.st != prrts_pkg::TS_SUSP) begin
              status_next = prrts_pkg::STS_ACTIVE;
              sw_next     = 1'b0;
              state_next  = prrts_pkg::S_DONE;
            end else begin
              tbl_wr.en      = 1'b1;
              tbl_wr.data.st = prrts_pkg::TS_WAIT;
            end
          end
        endcase
      end

      prrts_pkg::S_RB_INIT: begin
        head_next  = '0;
        fill_next  = '0;
        best_next  = 9'd256;
        idx_next   = '0;
        state_next = prrts_pkg::S_RB1_RD;
      end

      // First pass: find the best priority among non-suspended tasks.
      prrts_pkg::S_RB1_RD: begin
        if (idx == task_count) begin
          idx_next   = '0;
          state_next = prrts_pkg::S_RB2_RD;
        end else begin
          state_next = prrts_pkg::S_RB1_PR;
        end
      end

      prrts_pkg::S_RB1_PR: begin
        if (ent.st != prrts_pkg::TS_SUSP && {1'b0, ent.prio} < best) begin
          best_next = {1'b0, ent.prio};
        end
        idx_next   = idx + CW'(1);
        state_next = prrts_pkg::S_RB1_RD;
      end

      // Second pass: queue those tasks in slot order and mark them ready.
      prrts_pkg::S_RB2_RD: begin
        if (idx == task_count) begin
          state_next = do_next ? prrts_pkg::S_NX_RD : prrts_pkg::S_DONE;
        end else begin
          state_next = prrts_pkg::S_RB2_PR;
        end
      end

      prrts_pkg::S_RB2_PR: begin
        if (ent.st != prrts_pkg::TS_SUSP && {1'b0, ent.prio} == best) begin
          if (fill < CW'(NT)) begin
            fifo_wr.en   = 1'b1;
            fifo_wr.addr = push_addr;
            fifo_wr.id   = idx[IW-1:0];
            fill_next    = fill + CW'(1);
          end
          tbl_wr.en      = 1'b1;
          tbl_wr.addr    = idx[IW-1:0];
          tbl_wr.data    = ent;
          tbl_wr.data.st = prrts_pkg::TS_READY;
        end
        idx_next   = idx + CW'(1);
        state_next = prrts_pkg::S_RB2_RD;
      end

      // Tick: count blocked delays down and wake expired tasks.
      prrts_pkg::S_TK_RD: begin
        if (idx == task_count) begin
          state_next = woke ? prrts_pkg::S_RB_INIT : prrts_pkg::S_NX_RD;
        end else begin
          state_next = prrts_pkg::S_TK_PR;
        end
      end

      prrts_pkg::S_TK_PR: begin
        tbl_wr.addr = idx[IW-1:0];
        tbl_wr.data = ent;
        if (ent.st == prrts_pkg::TS_SUSP && ent.blk) begin
          tbl_wr.en = 1'b1;
          if (ent.delay <= 16'd1) begin
            tbl_wr.data.delay = '0;
            tbl_wr.data.blk   = 1'b0;
            tbl_wr.data.st    = prrts_pkg::TS_WAIT;
            woke_next         = 1'b1;
          end else begin
            tbl_wr.data.delay = ent.delay - 16'd1;
          end
        end
        idx_next   = idx + CW'(1);
        state_next = prrts_pkg::S_TK_RD;
      end

      // Next-task rule: read current entry and queue head together.
      prrts_pkg::S_NX_RD: begin
        tbl_raddr  = cur;
        fifo_raddr = head;
        state_next = prrts_pkg::S_NX_CUR;
      end

      prrts_pkg::S_NX_CUR: begin
        cur_ent_next = ent;
        if (fill == '0) begin
          // Empty queue: keep the current task, requeue it unless suspended.
          if (ent.st != prrts_pkg::TS_SUSP) begin
            fifo_wr.en   = 1'b1;
            fifo_wr.addr = push_addr;
            fifo_wr.id   = cur;
            fill_next    = fill + CW'(1);
          end
          state_next = prrts_pkg::S_DONE;
        end else begin
          nxt_id_next = fifo_rdata;
          tbl_raddr   = fifo_rdata;
          head_next   = head + IW'(1);
          fill_next   = fill - CW'(1);
          state_next  = prrts_pkg::S_NX_NXT;
        end
      end

      prrts_pkg::S_NX_NXT: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = nxt_id;
        tbl_wr.data = ent;
        if (nxt_id == cur) begin
          // Same slot: it runs, then rotates straight back to the tail.
          tbl_wr.data.st = prrts_pkg::TS_READY;
          if (fill < CW'(NT)) begin
            fifo_wr.en   = 1'b1;
            fifo_wr.addr = push_addr;
            fifo_wr.id   = cur;
            fill_next    = fill + CW'(1);
          end
          state_next = prrts_pkg::S_DONE;
        end else begin
          tbl_wr.data.st = prrts_pkg::TS_RUN;
          if (ent.prio == cur_ent.prio && cur_ent.st != prrts_pkg::TS_SUSP) begin
            state_next = prrts_pkg::S_NX_CURW;
          end else begin
            cur_next   = nxt_id;
            state_next = prrts_pkg::S_DONE;
          end
        end
      end

      prrts_pkg::S_NX_CURW: begin
        tbl_wr.en      = 1'b1;
        tbl_wr.addr    = cur;
        tbl_wr.data    = cur_ent;
        tbl_wr.data.st = prrts_pkg::TS_READY;
        if (fill < CW'(NT)) begin
          fifo_wr.en   = 1'b1;
          fifo_wr.addr = push_addr;
          fifo_wr.id   = cur;
          fill_next    = fill + CW'(1);
        end
        cur_next   = nxt_id;
        state_next = prrts_pkg::S_DONE;
      end

      // Hand the result over once the output register is free.
      prrts_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = prrts_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = prrts_pkg::S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= prrts_pkg::S_IDLE;
      task_count <= CW'(1);
      head       <= '0;
      fill       <= '0;
      cur        <= prrts_pkg::IDLE_SLOT;
      running    <= 1'b0;
      out_valid  <= 1'b0;
      do_next    <= 1'b0;
      woke       <= 1'b0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      task_count <= task_count_next;
      head       <= head_next;
      fill       <= fill_next;
      cur        <= cur_next;
      running    <= running_next;
      out_valid  <= out_valid_next;
      do_next    <= do_next_next;
      woke       <= woke_next;
      idx        <= idx_next;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    id_q    <= id_q_next;
    prio_q  <= prio_q_next;
    ticks_q <= ticks_q_next;
    status  <= status_next;
    new_id  <= new_id_next;
    sw      <= sw_next;
    best    <= best_next;
    cur_ent <= cur_ent_next;
    nxt_id  <= nxt_id_next;
    if (out_load) begin
      out_status  <= status_next;
      out_new_id  <= new_id_next;
      out_running <= cur_next;
      out_sw      <= sw_next;
      out_count   <= fill_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.new_task_id    = out_new_id;
  assign rsp.running_task   = out_running;
  assign rsp.switch_request = out_sw;
  assign rsp.ready_count    = out_count;

  `ASSERT_ALWAYS(a_fill_bound, fill <= CW'(NT), "ready queue overfilled")
  `ASSERT_ALWAYS(a_count_bound, (task_count >= CW'(1)) && (task_count <= CW'(NT)), "bad count")
  `ASSERT_ALWAYS(a_cur_valid, CW'(cur) < task_count, "current task outside the table")
  `ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state != prrts_pkg::S_IDLE, "transfer not taken up")

endmodule
